FILE: rtl/core/spc_pkg.sv
// sprite collision package: types, request codes, sizes and helper functions
// used by spc_geom and sprite_pixel_collision
`default_nettype none
package spc_pkg;

    localparam int NUM_SPRITES = 64;
    localparam int SPR_W       = 6;
    localparam int NUM_CHARS   = 256;
    localparam int CHR_W       = 8;
    localparam int ROW_W       = CHR_W + 3;
    localparam int ROWS        = NUM_CHARS * 8;

    typedef enum logic [1:0] {
        REQ_SPR   = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_CHECK = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_SW = 2'd0,
        CFG_SH = 2'd1,
        CFG_OX = 2'd2,
        CFG_OY = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       fy;
        logic       fx;
        logic [1:0] size;
        logic [7:0] ch;
        logic [7:0] y;
        logic [7:0] x;
    } t_spr;

    typedef struct packed {
        logic [7:0] sw;
        logic [7:0] sh;
        logic [7:0] ox;
        logic [7:0] oy;
    } t_cfg;

    typedef struct packed {
        logic a_on;
        logic b_on;
        logic overlap;
    } t_geom;

    function automatic logic [5:0] side_of(input logic [1:0] size);
        return {size + 2'd1 == 2'd0, size + 2'd1, 3'b000};
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/spc_geom.sv
// screen visibility and bounding box overlap of two sprites
// depends on spc_pkg
`default_nettype none
module spc_geom (
    input  spc_pkg::t_cfg  i_cfg,
    input  spc_pkg::t_spr  i_a,
    input  spc_pkg::t_spr  i_b,
    output spc_pkg::t_geom o_geom
);
    import spc_pkg::*;

    logic [8:0] s_xe, s_ye, s_ax1, s_ay1, s_bx1, s_by1;

    assign s_xe  = {1'b0, i_cfg.sw} + {1'b0, i_cfg.ox};
    assign s_ye  = {1'b0, i_cfg.sh} + {1'b0, i_cfg.oy};
    assign s_ax1 = {1'b0, i_a.x} + {3'b0, side_of(i_a.size)};
    assign s_ay1 = {1'b0, i_a.y} + {3'b0, side_of(i_a.size)};
    assign s_bx1 = {1'b0, i_b.x} + {3'b0, side_of(i_b.size)};
    assign s_by1 = {1'b0, i_b.y} + {3'b0, side_of(i_b.size)};

    assign o_geom.a_on = ({1'b0, i_a.x} < s_xe) && ({1'b0, i_a.y} < s_ye)
                      && (s_ax1 > {1'b0, i_cfg.ox}) && (s_ay1 > {1'b0, i_cfg.oy});
    assign o_geom.b_on = ({1'b0, i_b.x} < s_xe) && ({1'b0, i_b.y} < s_ye)
                      && (s_bx1 > {1'b0, i_cfg.ox}) && (s_by1 > {1'b0, i_cfg.oy});
    assign o_geom.overlap = (s_ax1 > {1'b0, i_b.x}) && (s_ay1 > {1'b0, i_b.y})
                         && ({1'b0, i_a.x} < s_bx1) && ({1'b0, i_a.y} < s_by1);

endmodule
`default_nettype wire

FILE: rtl/core/sprite_pixel_collision.sv
// sprite_pixel_collision: pixel exact collision check over a sprite table and
// character memory; depends on spc_pkg and spc_geom
//
// After reset the character memory is cleared row by row, all 2048 rows,
// during which no item is taken. A check reads the checked sprite and, if it is
// on screen, each sprite of the range in turn; for each overlapping sprite and
// line of the checked sprite it reads one character memory row per character
// column of both sprites. No new item is taken until the result of the last one
// is placed in the output register. The character memory has a single read port.
`default_nettype none
module sprite_pixel_collision (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sprite_index, pos_x, pos_y, char_index, size_code, flip_x, flip_y,
    // byte_addr, byte_value, first_index, last_index
    input  logic [71:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit, hit_index
    output logic [7:0]  m_tdata
);
    import spc_pkg::*;

    typedef enum logic [11:0] {
        ST_CLR  = 12'b000000000001,
        ST_IDLE = 12'b000000000010,
        ST_ME   = 12'b000000000100,
        ST_ORD  = 12'b000000001000,
        ST_OTH  = 12'b000000010000,
        ST_LINE = 12'b000000100000,
        ST_TRD  = 12'b000001000000,
        ST_TCAP = 12'b000010000000,
        ST_CMP  = 12'b000100000000,
        ST_NXL  = 12'b001000000000,
        ST_NXS  = 12'b010000000000,
        ST_DONE = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    t_cfg   r_cfg;

    logic [27:0]      spr_mem [NUM_SPRITES];
    logic [15:0]      chr_mem [ROWS];
    logic [NUM_SPRITES-1:0] r_spr_vld;
    logic [27:0]      r_spr_q;
    logic             r_spr_qv;
    logic [15:0]      r_chr_q;
    logic [ROW_W-1:0] r_clr;

    logic [SPR_W-1:0] r_idx, r_first, r_last, r_j, r_last_hit;
    t_spr             r_me, r_oth;
    logic [8:0]       r_dx, r_dy;
    logic [4:0]       r_line, r_l1, r_l2;
    logic [1:0]       r_tile;
    logic             r_phb, r_hit;
    logic [31:0]      r_r1, r_r2;
    logic             r_m_valid, r_m_hit;
    logic [SPR_W-1:0] r_m_idx;

    logic             s_acc;
    t_req             s_req;
    logic [SPR_W-1:0] s_spr_ra;
    t_spr             s_rd, s_cur, s_geo_b;
    t_geom            s_geom;
    logic [ROW_W-1:0] s_chr_ra, s_wrow;
    logic             s_cwe, s_chi;
    logic [15:0]      s_cwd;
    logic [4:0]       s_ln;
    logic [1:0]       s_col;
    logic [7:0]       s_chr, s_v, s_pix;
    logic [9:0]       s_lb;
    logic [5:0]       s_side_a, s_side_b;
    logic [10:0]      s_sh;
    logic [39:0]      s_wide;
    logic             s_tile_end;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (r_state == ST_IDLE);
    assign s_req    = t_req'(s_tuser);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {1'b0, r_m_idx, r_m_hit};

    // sprite table
    assign s_spr_ra = (r_state == ST_IDLE) ? s_tdata[5:0] : r_j;
    always_ff @(posedge i_clk) begin
        if (s_acc && s_req == REQ_SPR) begin
            spr_mem[s_tdata[5:0]] <= s_tdata[33:6];
        end
        r_spr_q  <= spr_mem[s_spr_ra];
        r_spr_qv <= r_spr_vld[s_spr_ra];
    end
    assign s_rd = r_spr_qv ? t_spr'(r_spr_q) : '0;

    // character memory, one row holds both planes
    assign s_cur    = r_phb ? r_oth : r_me;
    assign s_ln     = r_phb ? r_l2 : r_l1;
    assign s_col    = s_cur.fx ? s_cur.size - r_tile : r_tile;
    assign s_chr    = s_cur.ch + {2'b0, s_ln[4:3], 4'b0} + {6'b0, s_col};
    assign s_chr_ra = {s_chr, s_ln[2:0]};
    assign s_cwe    = (r_state == ST_CLR) || (s_acc && s_req == REQ_BYTE);
    assign s_wrow   = (r_state == ST_CLR) ? r_clr : {s_tdata[45:38], s_tdata[36:34]};
    assign s_chi    = s_tdata[37];
    assign s_cwd    = (r_state == ST_CLR) ? 16'h0 :
                      (s_chi ? {s_tdata[53:46], 8'h0} : {8'h0, s_tdata[53:46]});
    always_ff @(posedge i_clk) begin
        if (s_cwe) begin
            if (r_state == ST_CLR) begin
                chr_mem[s_wrow] <= s_cwd;
            end else if (s_chi) begin
                chr_mem[s_wrow][15:8] <= s_cwd[15:8];
            end else begin
                chr_mem[s_wrow][7:0] <= s_cwd[7:0];
            end
        end
        r_chr_q <= chr_mem[s_chr_ra];
    end

    assign s_geo_b = (r_state == ST_ME) ? s_rd : s_rd;
    spc_geom u_geom (
        .i_cfg  (r_cfg),
        .i_a    ((r_state == ST_ME) ? s_rd : r_me),
        .i_b    (s_geo_b),
        .o_geom (s_geom)
    );

    assign s_side_a   = side_of(r_me.size);
    assign s_side_b   = side_of(r_oth.size);
    assign s_lb       = {5'b0, r_line} - {r_dy[8], r_dy};
    assign s_v        = r_chr_q[7:0] | r_chr_q[15:8];
    assign s_pix      = s_cur.fx ? reverse8(s_v) : s_v;
    assign s_sh       = 11'd8 + {6'b0, r_tile, 3'b0} + {{2{r_dx[8]}}, r_dx};
    assign s_wide     = {s_pix, 32'h0} >> s_sh[5:0];
    assign s_tile_end = (r_tile == s_cur.size);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:  if (&r_clr) n_state = ST_IDLE;
            ST_IDLE: if (s_acc) n_state = (s_req == REQ_CHECK) ? ST_ME : ST_DONE;
            ST_ME:   n_state = (s_geom.a_on && r_last >= r_first) ? ST_ORD : ST_DONE;
            ST_ORD:  n_state = ST_OTH;
            ST_OTH:  n_state = (r_j != r_idx && s_geom.b_on && s_geom.overlap)
                               ? ST_LINE : ST_NXS;
            ST_LINE: n_state = (s_lb[9] || s_lb >= {4'b0, s_side_b}) ? ST_NXL : ST_TRD;
            ST_TRD:  n_state = ST_TCAP;
            ST_TCAP: n_state = (s_tile_end && r_phb) ? ST_CMP : ST_TRD;
            ST_CMP:  n_state = (|(r_r1 & r_r2)) ? ST_DONE : ST_NXL;
            ST_NXL:  n_state = (r_line == s_side_a[4:0] - 5'd1) ? ST_NXS : ST_LINE;
            ST_NXS:  n_state = (r_j == r_last) ? ST_DONE : ST_ORD;
            ST_DONE: if (!r_m_valid || m_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr      <= '0;
            r_cfg      <= '{sw: 8'd160, sh: 8'd128, ox: 8'd32, oy: 8'd32};
            r_spr_vld  <= '0;
            r_last_hit <= '0;
            r_m_valid  <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SW:  r_cfg.sw <= i_cfg_data;
                    CFG_SH:  r_cfg.sh <= i_cfg_data;
                    CFG_OX:  r_cfg.ox <= i_cfg_data;
                    CFG_OY:  r_cfg.oy <= i_cfg_data;
                    default: r_cfg.sw <= r_cfg.sw;
                endcase
            end
            if (s_acc) begin
                r_hit <= 1'b0;
                if (s_req == REQ_SPR) r_spr_vld[s_tdata[5:0]] <= 1'b1;
            end
            if (r_state == ST_CMP && |(r_r1 & r_r2)) begin
                r_hit      <= 1'b1;
                r_last_hit <= r_j;
            end
            if (r_state == ST_DONE && (!r_m_valid || m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_idx   <= s_tdata[5:0];
            r_first <= s_tdata[59:54];
            r_last  <= s_tdata[65:60];
        end
        case (r_state)
            ST_ME: begin
                r_me <= s_rd;
                r_j  <= r_first;
            end
            ST_OTH: begin
                r_oth  <= s_rd;
                r_dx   <= {1'b0, s_rd.x} - {1'b0, r_me.x};
                r_dy   <= {1'b0, s_rd.y} - {1'b0, r_me.y};
                r_line <= '0;
            end
            ST_LINE: begin
                r_l1   <= r_me.fy ? {r_me.size, 3'b111} - r_line : r_line;
                r_l2   <= r_oth.fy ? {r_oth.size, 3'b111} - s_lb[4:0] : s_lb[4:0];
                r_tile <= '0;
                r_phb  <= 1'b0;
                r_r1   <= '0;
                r_r2   <= '0;
            end
            ST_TCAP: begin
                if (!r_phb) begin
                    r_r1 <= r_r1 | ({24'h0, s_pix} << {~r_tile, 3'b000});
                end else if (!s_sh[10] && s_sh != 11'd0 && s_sh < 11'd64) begin
                    r_r2 <= r_r2 | s_wide[31:0];
                end
                if (s_tile_end) begin
                    r_tile <= '0;
                    r_phb  <= 1'b1;
                end else begin
                    r_tile <= r_tile + 1'b1;
                end
            end
            ST_NXL:  r_line <= r_line + 1'b1;
            ST_NXS:  r_j    <= r_j + 1'b1;
            ST_DONE: begin
                if (!r_m_valid || m_tready) begin
                    r_m_hit <= r_hit;
                    r_m_idx <= r_last_hit;
                end
            end
            default: r_line <= r_line;
        endcase
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLR |-> !s_tready) else $error("item taken during clear");
    a_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CMP && |(r_r1 & r_r2) |=> r_last_hit == $past(r_j))
        else $error("hit index not kept");
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LINE |-> {1'b0, r_line} < s_side_a)
        else $error("line beyond sprite");
    a_self_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LINE |-> r_j != r_idx) else $error("sprite checked against itself");

endmodule
`default_nettype wire

FILE: test/testbench.sv
// testbench for sprite_pixel_collision: drives sprite, character and check items
// over the stream ports and compares every result with its own behavioral predictor
// depends on spc_pkg and sprite_pixel_collision
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import spc_pkg::*;

    typedef struct {
        t_req        req;
        logic [5:0]  spr;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [7:0]  ch;
        logic [1:0]  size;
        logic        fx;
        logic        fy;
        logic [11:0] addr;
        logic [7:0]  val;
        logic [5:0]  first;
        logic [5:0]  last;
    } t_item;

    typedef struct {
        logic       hit;
        logic [5:0] hidx;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    sprite_pixel_collision i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    t_spr       spr_table [NUM_SPRITES];
    logic [7:0] chr_mem [NUM_CHARS*16];
    logic [5:0] kept_hit;
    logic [7:0] scr_w = 8'd160, scr_h = 8'd128, org_x = 8'd32, org_y = 8'd32;

    t_outcome pending_results [$];
    int       errors = 0;
    bit       no_idle = 1'b0;
    int       rx_hold = 0;
    int       rx_stall = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit on_screen(input t_spr s);
        int side;
        side = (int'(s.size) + 1) * 8;
        return int'(s.x) < int'(scr_w) + int'(org_x) && int'(s.y) < int'(scr_h) + int'(org_y)
            && int'(s.x) + side > int'(org_x) && int'(s.y) + side > int'(org_y);
    endfunction

    function automatic logic [31:0] row_byte(input t_spr s, input int ln, input int col_i);
        int         col;
        int         chr;
        int         base;
        logic [7:0] v;
        col = s.fx ? (int'(s.size) - col_i) : col_i;
        chr = (int'(s.ch) + ((ln >> 3) << 4) + col) % NUM_CHARS;
        base = chr * 16 + (ln & 7);
        v = chr_mem[base] | chr_mem[base + 8];
        if (s.fx) v = {<<{v}};
        return {24'd0, v};
    endfunction

    function automatic bit sprites_touch(input t_spr a, input t_spr b);
        int          sa, sb, dx, dy, lb, l1, l2, sh;
        logic [31:0] r1, r2, v;
        if (!on_screen(b)) return 1'b0;
        sa = (int'(a.size) + 1) * 8;
        sb = (int'(b.size) + 1) * 8;
        if (!(int'(a.x) + sa > int'(b.x) && int'(a.y) + sa > int'(b.y)
              && int'(a.x) < int'(b.x) + sb && int'(a.y) < int'(b.y) + sb))
            return 1'b0;
        dx = int'(b.x) - int'(a.x);
        dy = int'(b.y) - int'(a.y);
        for (int ln = 0; ln < sa; ln++) begin
            lb = ln - dy;
            if (lb < 0 || lb >= sb) continue;
            l1 = a.fy ? (sa - ln - 1) : ln;
            l2 = b.fy ? (sb - lb - 1) : lb;
            r1 = '0;
            r2 = '0;
            for (int i = 0; i <= int'(a.size); i++) r1 |= row_byte(a, l1, i) << (24 - 8 * i);
            for (int i = 0; i <= int'(b.size); i++) begin
                v = row_byte(b, l2, i);
                sh = 24 - 8 * i - dx;
                if (sh >= 0 && sh < 32) r2 |= v << sh;
                else if (sh < 0 && sh > -32) r2 |= v >> (-sh);
            end
            if ((r1 & r2) != 0) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_outcome predict_outcome(input t_item it);
        t_outcome o;
        t_spr     me;
        o.hit = 1'b0;
        case (it.req)
            REQ_SPR: spr_table[it.spr] = '{fy: it.fy, fx: it.fx, size: it.size, ch: it.ch,
                                          y: it.py, x: it.px};
            REQ_BYTE: chr_mem[it.addr] = it.val;
            REQ_CHECK: begin
                me = spr_table[it.spr];
                if (on_screen(me)) begin
                    for (int j = int'(it.first); j <= int'(it.last); j++) begin
                        if (j == int'(it.spr)) continue;
                        if (sprites_touch(me, spr_table[j])) begin
                            kept_hit = j[5:0];
                            o.hit = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        o.hidx = kept_hit;
        return o;
    endfunction

    function automatic t_item noise_item();
        t_item it;
        it.req = t_req'($urandom_range(0, 3));
        it.spr = 6'($urandom);
        it.px = 8'($urandom);
        it.py = 8'($urandom);
        it.ch = 8'($urandom);
        it.size = 2'($urandom);
        it.fx = 1'($urandom);
        it.fy = 1'($urandom);
        it.addr = 12'($urandom);
        it.val = 8'($urandom);
        it.first = 6'($urandom);
        it.last = 6'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tuser = it.req;
        s_tdata = {6'd0, it.last, it.first, it.val, it.addr, it.fy, it.fx, it.size,
                   it.ch, it.py, it.px, it.spr};
        s_tvalid = 1'b1;
        pending_results.push_back(predict_outcome(it));
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic put_sprite(input int idx, input int x, input int y, input int ch,
                              input int size, input bit fx, input bit fy);
        t_item it;
        it = noise_item();
        it.req = REQ_SPR;
        it.spr = idx[5:0];
        it.px = x[7:0];
        it.py = y[7:0];
        it.ch = ch[7:0];
        it.size = size[1:0];
        it.fx = fx;
        it.fy = fy;
        send_item(it);
    endtask

    task automatic put_byte(input int addr, input int val);
        t_item it;
        it = noise_item();
        it.req = REQ_BYTE;
        it.addr = addr[11:0];
        it.val = val[7:0];
        send_item(it);
    endtask

    task automatic run_check(input int idx, input int first, input int last);
        t_item it;
        it = noise_item();
        it.req = REQ_CHECK;
        it.spr = idx[5:0];
        it.first = first[5:0];
        it.last = last[5:0];
        send_item(it);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_SW: scr_w = val;
            CFG_SH: scr_h = val;
            CFG_OX: org_x = val;
            default: org_y = val;
        endcase
    endtask

    task automatic test_directed();
        t_item it;
        for (int b = 0; b < 16; b++) put_byte(b, (b & 1) ? 8'hff : 8'h81);
        put_byte(255 * 16 + 3, 8'h18);
        put_byte(4095, 8'hff);
        put_sprite(0, 40, 40, 0, 0, 0, 0);
        put_sprite(1, 44, 42, 0, 1, 1, 0);
        put_sprite(2, 40, 40, 255, 1, 0, 1);
        put_sprite(63, 255, 255, 255, 3, 1, 1);
        run_check(0, 0, 63);
        run_check(1, 0, 0);
        run_check(2, 63, 0);
        run_check(63, 0, 63);
        run_check(0, 2, 2);
        put_sprite(3, 0, 0, 0, 0, 0, 0);
        run_check(3, 0, 63);
        run_check(0, 3, 3);
        it = noise_item();
        it.req = REQ_NONE;
        send_item(it);
        run_check(2, 0, 63);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_SW, 8'd255);
        write_reg(CFG_SH, 8'd255);
        write_reg(CFG_OX, 8'd0);
        write_reg(CFG_OY, 8'd0);
        run_check(3, 0, 63);
        run_check(63, 0, 63);
        drain();
        write_reg(CFG_SW, 8'd1);
        write_reg(CFG_SH, 8'd1);
        write_reg(CFG_OX, 8'd255);
        write_reg(CFG_OY, 8'd255);
        run_check(63, 0, 63);
        run_check(0, 0, 63);
        drain();
        write_reg(CFG_SW, 8'd160);
        write_reg(CFG_SH, 8'd128);
        write_reg(CFG_OX, 8'd32);
        write_reg(CFG_OY, 8'd32);
    endtask

    task automatic random_phase(input int count);
        int pick, lo;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                if ($urandom_range(0, 9) == 0)
                    put_sprite($urandom_range(0, 63), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1));
                else
                    put_sprite($urandom_range(0, 15), int'(org_x) + $urandom_range(0, 40) - 8,
                               int'(org_y) + $urandom_range(0, 40) - 8,
                               $urandom_range(0, 20) + ($urandom_range(0, 7) == 0 ? 240 : 0),
                               $urandom_range(0, 4) == 0 ? 3 : $urandom_range(0, 1),
                               $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (pick < 65) begin
                if ($urandom_range(0, 4) == 0)
                    put_byte($urandom_range(0, 4095), $urandom_range(0, 255));
                else
                    put_byte($urandom_range(0, 511), $urandom_range(0, 255));
            end else if (pick < 95) begin
                lo = $urandom_range(0, 20);
                run_check($urandom_range(0, 17), lo, $urandom_range(0, 3) == 0 ?
                          $urandom_range(0, 63) : lo + $urandom_range(0, 16));
            end else begin
                send_item(noise_item());
            end
        end
        drain();
    endtask

    task automatic test_random();
        random_phase(80);
        write_reg(CFG_OX, 8'd10);
        write_reg(CFG_OY, 8'd60);
        write_reg(CFG_SW, 8'd30);
        write_reg(CFG_SH, 8'd20);
        random_phase(80);
        write_reg(CFG_SW, 8'd160);
        write_reg(CFG_SH, 8'd128);
        write_reg(CFG_OX, 8'd32);
        write_reg(CFG_OY, 8'd32);
        no_idle = 1'b1;
        random_phase(50);
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        @(negedge i_clk);
        rx_hold = 3000;
        for (int n = 0; n < 30; n++) begin
            if (n % 3 == 0) run_check($urandom_range(0, 15), 0, 15);
            else put_byte($urandom_range(0, 255), $urandom_range(0, 255));
        end
        drain();
        random_phase(20);
    endtask

    // receiver ready, with per item stalls and an optional long hold
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                m_tready = 1'b0;
                rx_stall--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected item", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.hit) report("hit", m_tdata[0], want.hit);
                if (m_tdata[6:1] !== want.hidx) report("hit_index", m_tdata[6:1], want.hidx);
            end
            rx_stall = no_idle ? 0 : $urandom_range(0, 13);
        end
    end

    initial begin
        for (int k = 0; k < NUM_SPRITES; k++) spr_table[k] = '0;
        for (int k = 0; k < NUM_CHARS * 16; k++) chr_mem[k] = '0;
        kept_hit = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_random();
        test_backpressure();
        if (pending_results.size() != 0) errors++;
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/spc_pkg.sv
rtl/core/spc_geom.sv
rtl/core/sprite_pixel_collision.sv
test/testbench.sv
